>>> rtl/core/bbes_pkg.sv
`timescale 1ns / 1ps

package bbes_pkg;

	localparam logic [1:0] OP_RESET  = 2'd0;
	localparam logic [1:0] OP_LAUNCH = 2'd1;
	localparam logic [1:0] OP_TICK   = 2'd2;

	localparam logic [2:0] REG_RADIUS      = 3'd0;
	localparam logic [2:0] REG_LEFT        = 3'd1;
	localparam logic [2:0] REG_RIGHT       = 3'd2;
	localparam logic [2:0] REG_GROUND      = 3'd3;
	localparam logic [2:0] REG_CEILING     = 3'd4;
	localparam logic [2:0] REG_GRAVITY     = 3'd5;
	localparam logic [2:0] REG_RESTITUTION = 3'd6;
	localparam logic [2:0] REG_INV_MASS    = 3'd7;

	localparam logic [30:0]        RST_RADIUS      = 31'd16384;
	localparam logic signed [31:0] RST_LEFT        = 32'sd0;
	localparam logic signed [31:0] RST_RIGHT       = 32'sd1310720;
	localparam logic signed [31:0] RST_GROUND      = 32'sd0;
	localparam logic signed [31:0] RST_CEILING     = 32'sd655360;
	localparam logic signed [31:0] RST_GRAVITY     = -32'sd642253;
	localparam logic [16:0]        RST_RESTITUTION = 17'd45875;
	localparam logic [24:0]        RST_INV_MASS    = 25'd32768;
	localparam logic signed [31:0] RST_BALL_X      = 32'sd16384;
	localparam logic signed [31:0] RST_BALL_Y      = 32'sd16384;

	// widest exact sum that gets saturated
	localparam int SAT_W = 44;
	localparam logic signed [SAT_W-1:0] SAT_HI = 44'sd2147483647;
	localparam logic signed [SAT_W-1:0] SAT_LO = -44'sd2147483648;

	typedef struct packed {
		logic [30:0]        radius;
		logic signed [31:0] left_wall;
		logic signed [31:0] right_wall;
		logic signed [31:0] ground;
		logic signed [31:0] ceiling;
		logic signed [31:0] gravity;
		logic [16:0]        restitution;
		logic [24:0]        inv_mass;
	} cfg_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
	} ball_t;

	// word after the input stage: op plus the products that need no ball state
	typedef struct packed {
		logic [1:0]         op;
		logic [15:0]        dt;
		logic signed [41:0] dv_x;
		logic signed [41:0] dv_y;
		logic signed [32:0] dv_grav;
	} item_t;

	typedef struct packed {
		ball_t      ball;
		logic [3:0] flags;
	} res_t;

	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic signed [31:0] r;
		if (v > SAT_HI)
			r = 32'sh7fffffff;
		else if (v < SAT_LO)
			r = -32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

>>> rtl/core/bouncing_ball_euler_step_unit.sv
`timescale 1ns / 1ps

// Ball in a rectangular room, one explicit Euler step per word, Q16.16.
// Input channel (in_valid / in_stall) carries op, force_x, force_y, time_step;
// op selects reset ball, launch or tick. Every input word gives one output
// word (out_valid / out_stall) with the ball state after that operation and
// the bounce flags of a tick.
// The accept edge loads an input register with the word and its force and
// gravity products; when that word moves on, the ball state is updated and
// the output register is loaded. Throughput is one word per cycle while the
// receiver does not stall; the state loop closes through the velocity times
// dt multiply, the position add and the wall compares.
// When the receiver stalls the output word holds, the input register fills,
// and then in_stall rises until the output word is taken.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user
// must do so only while the block is idle, which the block does not enforce.
// Asynchronous reset loads the default room, puts the ball at one radius from
// the left wall and the ground at rest, and empties both registers.

module bouncing_ball_euler_step_unit
	import bbes_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         op,
	input  logic signed [31:0] force_x,
	input  logic signed [31:0] force_y,
	input  logic [15:0]        time_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	output logic [3:0]         bounce_flags
);

	cfg_t  cfg_q;
	ball_t ball_q;
	item_t item_in, item_s1;
	logic  valid_s1;
	res_t  res_q;
	logic  out_valid_q;
	ball_t ball_next;
	logic [3:0] flags_next;
	logic  adv_s1, acc_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius      <= RST_RADIUS;
			cfg_q.left_wall   <= RST_LEFT;
			cfg_q.right_wall  <= RST_RIGHT;
			cfg_q.ground      <= RST_GROUND;
			cfg_q.ceiling     <= RST_CEILING;
			cfg_q.gravity     <= RST_GRAVITY;
			cfg_q.restitution <= RST_RESTITUTION;
			cfg_q.inv_mass    <= RST_INV_MASS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIUS:      cfg_q.radius      <= cfg_data[30:0];
				REG_LEFT:        cfg_q.left_wall   <= cfg_data;
				REG_RIGHT:       cfg_q.right_wall  <= cfg_data;
				REG_GROUND:      cfg_q.ground      <= cfg_data;
				REG_CEILING:     cfg_q.ceiling     <= cfg_data;
				REG_GRAVITY:     cfg_q.gravity     <= cfg_data;
				REG_RESTITUTION: cfg_q.restitution <= cfg_data[16:0];
				REG_INV_MASS:    cfg_q.inv_mass    <= cfg_data[24:0];
				default: ;
			endcase
		end
	end

	bbes_prep u_prep (
		.cfg       (cfg_q),
		.op        (op),
		.force_x   (force_x),
		.force_y   (force_y),
		.time_step (time_step),
		.item      (item_in)
	);

	bbes_step u_step (
		.cfg   (cfg_q),
		.ball  (ball_q),
		.item  (item_s1),
		.next  (ball_next),
		.flags (flags_next)
	);

	// input word moves on when the output register is free or being taken
	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign acc_in   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in)
			item_s1 <= item_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ball_q.x  <= RST_BALL_X;
			ball_q.y  <= RST_BALL_Y;
			ball_q.vx <= 32'sd0;
			ball_q.vy <= 32'sd0;
		end else if (adv_s1) begin
			ball_q <= ball_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q.ball  <= ball_next;
			res_q.flags <= flags_next;
		end
	end

	assign out_valid    = out_valid_q;
	assign pos_x        = res_q.ball.x;
	assign pos_y        = res_q.ball.y;
	assign vel_x        = res_q.ball.vx;
	assign vel_y        = res_q.ball.vy;
	assign bounce_flags = res_q.flags;

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without a blocked word");

	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid && pos_x == ball_q.x && pos_y == ball_q.y
			&& vel_x == ball_q.vx && vel_y == ball_q.vy)
		else $error("output word differs from ball state");

	a_one_wall_per_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(bounce_flags[0] && bounce_flags[1])
			&& !(bounce_flags[2] && bounce_flags[3]))
		else $error("both walls of one axis hit in one tick");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(ball_q))
		else $error("ball state changed without a word");

endmodule

>>> rtl/core/bbes_prep.sv
`timescale 1ns / 1ps

module bbes_prep
	import bbes_pkg::*;
(
	input  cfg_t               cfg,
	input  logic [1:0]         op,
	input  logic signed [31:0] force_x,
	input  logic signed [31:0] force_y,
	input  logic [15:0]        time_step,
	output item_t              item
);

	logic signed [25:0] inv_s;
	logic signed [16:0] dt_s;
	logic signed [57:0] px, py;
	logic signed [48:0] pg;

	always_comb begin
		inv_s = $signed({1'b0, cfg.inv_mass});
		dt_s  = $signed({1'b0, time_step});
		// round half up, floor shift by 16
		px = 58'(force_x) * 58'(inv_s) + 58'sd32768;
		py = 58'(force_y) * 58'(inv_s) + 58'sd32768;
		pg = 49'(dt_s) * 49'(cfg.gravity) + 49'sd32768;

		item.op      = op;
		item.dt      = time_step;
		item.dv_x    = px[57:16];
		item.dv_y    = py[57:16];
		item.dv_grav = pg[48:16];
	end

endmodule

>>> rtl/core/bbes_step.sv
`timescale 1ns / 1ps

module bbes_step
	import bbes_pkg::*;
(
	input  cfg_t  cfg,
	input  ball_t ball,
	input  item_t item,
	output ball_t next,
	output logic [3:0] flags
);

	logic signed [16:0] dt_s;
	logic signed [31:0] r_s;
	logic signed [17:0] rest_s;
	logic signed [48:0] mx, my;
	logic signed [50:0] bx, by;
	logic signed [31:0] bvx, bvy;
	logic signed [31:0] mvx, mvy, vy_b;
	logic signed [33:0] lo_y, hi_y, lo_x, hi_x;
	logic signed [31:0] x_left, x_right, y_ground, y_ceil;
	logic hit_g, hit_c, hit_l, hit_r;

	always_comb begin
		dt_s   = $signed({1'b0, item.dt});
		r_s    = $signed({1'b0, cfg.radius});
		rest_s = $signed({1'b0, cfg.restitution});

		mx = 49'(dt_s) * 49'(ball.vx) + 49'sd32768;
		my = 49'(dt_s) * 49'(ball.vy) + 49'sd32768;
		// bounce speed uses the velocity from before the tick
		bx = (-51'(ball.vx)) * 51'(rest_s) + 51'sd32768;
		by = (-51'(ball.vy)) * 51'(rest_s) + 51'sd32768;
		bvx = sat32(SAT_W'($signed(bx[50:16])));
		bvy = sat32(SAT_W'($signed(by[50:16])));

		mvx = sat32(SAT_W'(ball.x) + SAT_W'($signed(mx[48:16])));
		mvy = sat32(SAT_W'(ball.y) + SAT_W'($signed(my[48:16])));

		lo_y = 34'(mvy) - 34'(r_s);
		hi_y = 34'(mvy) + 34'(r_s);
		lo_x = 34'(mvx) - 34'(r_s);
		hi_x = 34'(mvx) + 34'(r_s);

		x_left   = sat32(SAT_W'(cfg.left_wall) + SAT_W'(r_s));
		x_right  = sat32(SAT_W'(cfg.right_wall) - SAT_W'(r_s));
		y_ground = sat32(SAT_W'(cfg.ground) + SAT_W'(r_s));
		y_ceil   = sat32(SAT_W'(cfg.ceiling) - SAT_W'(r_s));

		hit_g = (lo_y < 34'(cfg.ground)) && (ball.vy < 32'sd0);
		hit_c = !hit_g && (hi_y > 34'(cfg.ceiling)) && (ball.vy > 32'sd0);
		hit_l = (lo_x < 34'(cfg.left_wall)) && (ball.vx < 32'sd0);
		hit_r = !hit_l && (hi_x > 34'(cfg.right_wall)) && (ball.vx > 32'sd0);

		vy_b = (hit_g || hit_c) ? bvy : ball.vy;

		next  = ball;
		flags = 4'd0;
		case (item.op)
			OP_RESET: begin
				next.x  = x_left;
				next.y  = r_s;
				next.vx = 32'sd0;
				next.vy = 32'sd0;
			end
			OP_LAUNCH: begin
				next.vx = sat32(SAT_W'(ball.vx) + SAT_W'(item.dv_x));
				next.vy = sat32(SAT_W'(ball.vy) + SAT_W'(item.dv_y));
			end
			OP_TICK: begin
				next.x  = hit_l ? x_left : (hit_r ? x_right : mvx);
				next.y  = hit_g ? y_ground : (hit_c ? y_ceil : mvy);
				next.vx = (hit_l || hit_r) ? bvx : ball.vx;
				next.vy = sat32(SAT_W'(vy_b) + SAT_W'(item.dv_grav));
				flags   = {hit_r, hit_l, hit_c, hit_g};
			end
			default: begin
				next  = ball;
				flags = 4'd0;
			end
		endcase
	end

endmodule

>>> bench/bouncing_ball_euler_step_unit_tb.sv
`timescale 1ns / 1ps

module bouncing_ball_euler_step_unit_tb;
	import bbes_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	// tracks the ball and the room, one expected word per accepted input word
	class ball_tracker;
		cfg_t  room;
		ball_t ball;
		res_t  expected_words[$];
		int    mismatches;

		function new();
			room.radius      = RST_RADIUS;
			room.left_wall   = RST_LEFT;
			room.right_wall  = RST_RIGHT;
			room.ground      = RST_GROUND;
			room.ceiling     = RST_CEILING;
			room.gravity     = RST_GRAVITY;
			room.restitution = RST_RESTITUTION;
			room.inv_mass    = RST_INV_MASS;
			ball.x  = RST_BALL_X;
			ball.y  = RST_BALL_Y;
			ball.vx = '0;
			ball.vy = '0;
			mismatches = 0;
		endfunction

		function longint wide(logic signed [31:0] v);
			return longint'(v);
		endfunction

		function logic signed [31:0] clip32(longint v);
			if (v > 64'sd2147483647)
				return 32'sh7fffffff;
			if (v < -64'sd2147483648)
				return 32'sh80000000;
			return v[31:0];
		endfunction

		// exact product, round half up back to 16 fraction bits
		function longint q_product(longint a, longint b);
			return (a * b + 64'sd32768) >>> 16;
		endfunction

		function int outstanding();
			return expected_words.size();
		endfunction

		function void load_reg(logic [2:0] idx, logic [31:0] data);
			case (idx)
				REG_RADIUS:      room.radius = data[30:0];
				REG_LEFT:        room.left_wall = data;
				REG_RIGHT:       room.right_wall = data;
				REG_GROUND:      room.ground = data;
				REG_CEILING:     room.ceiling = data;
				REG_GRAVITY:     room.gravity = data;
				REG_RESTITUTION: room.restitution = data[16:0];
				REG_INV_MASS:    room.inv_mass = data[24:0];
				default: ;
			endcase
		endfunction

		function void note_word(logic [1:0] o, logic signed [31:0] fx,
				logic signed [31:0] fy, logic [15:0] dt);
			longint r, x, y, u, w, t, rest;
			logic [3:0] fl;
			res_t exp_word;
			r = longint'(room.radius);
			rest = longint'(room.restitution);
			x = wide(ball.x);
			y = wide(ball.y);
			u = wide(ball.vx);
			w = wide(ball.vy);
			fl = '0;
			case (o)
				OP_RESET: begin
					x = clip32(wide(room.left_wall) + r);
					y = r;
					u = 0;
					w = 0;
				end
				OP_LAUNCH: begin
					u = clip32(u + q_product(wide(fx), longint'(room.inv_mass)));
					w = clip32(w + q_product(wide(fy), longint'(room.inv_mass)));
				end
				OP_TICK: begin
					t = longint'(dt);
					x = clip32(x + q_product(t, u));
					y = clip32(y + q_product(t, w));
					if (y - r < wide(room.ground) && w < 0) begin
						y = clip32(wide(room.ground) + r);
						w = clip32(q_product(-w, rest));
						fl[0] = 1'b1;
					end else if (y + r > wide(room.ceiling) && w > 0) begin
						y = clip32(wide(room.ceiling) - r);
						w = clip32(q_product(-w, rest));
						fl[1] = 1'b1;
					end
					if (x - r < wide(room.left_wall) && u < 0) begin
						x = clip32(wide(room.left_wall) + r);
						u = clip32(q_product(-u, rest));
						fl[2] = 1'b1;
					end else if (x + r > wide(room.right_wall) && u > 0) begin
						x = clip32(wide(room.right_wall) - r);
						u = clip32(q_product(-u, rest));
						fl[3] = 1'b1;
					end
					w = clip32(w + q_product(t, wide(room.gravity)));
				end
				default: ;
			endcase
			ball.x  = x[31:0];
			ball.y  = y[31:0];
			ball.vx = u[31:0];
			ball.vy = w[31:0];
			exp_word.ball  = ball;
			exp_word.flags = fl;
			expected_words.push_back(exp_word);
		endfunction

		function void check_word(logic signed [31:0] px, logic signed [31:0] py,
				logic signed [31:0] vx, logic signed [31:0] vy, logic [3:0] fl);
			res_t e;
			if (expected_words.size() == 0) begin
				$error("output word with nothing expected: pos_x %0d pos_y %0d", px, py);
				mismatches++;
				return;
			end
			e = expected_words.pop_front();
			if (px !== e.ball.x) begin
				$error("pos_x expected %0d actual %0d", e.ball.x, px);
				mismatches++;
			end
			if (py !== e.ball.y) begin
				$error("pos_y expected %0d actual %0d", e.ball.y, py);
				mismatches++;
			end
			if (vx !== e.ball.vx) begin
				$error("vel_x expected %0d actual %0d", e.ball.vx, vx);
				mismatches++;
			end
			if (vy !== e.ball.vy) begin
				$error("vel_y expected %0d actual %0d", e.ball.vy, vy);
				mismatches++;
			end
			if (fl !== e.flags) begin
				$error("bounce_flags expected %h actual %h", e.flags, fl);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n = 1'b1;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         op = '0;
	logic signed [31:0] force_x = '0;
	logic signed [31:0] force_y = '0;
	logic [15:0]        time_step = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic [3:0]         bounce_flags;

	ball_tracker sb;
	bit hold_kick = 1'b0;
	int hold_left = 0;
	int stall_pct = 0;
	int mode_left = 0;
	int burst_left = 0;

	bouncing_ball_euler_step_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.force_x(force_x),
		.force_y(force_y),
		.time_step(time_step),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.vel_x(vel_x),
		.vel_y(vel_y),
		.bounce_flags(bounce_flags)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

	// receiver: stall density changes in stretches, long hold-off on request
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			sb.check_word(pos_x, pos_y, vel_x, vel_y, bounce_flags);
		if (mode_left == 0) begin
			case ($urandom_range(3))
				0: stall_pct = 0;
				1: stall_pct = 20;
				2: stall_pct = 50;
				default: stall_pct = 85;
			endcase
			mode_left = $urandom_range(16, 128);
		end
		mode_left--;
		if (hold_kick) begin
			hold_left = 80;
			hold_kick = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send_word(logic [1:0] o, logic [31:0] fx, logic [31:0] fy,
			logic [15:0] dt);
		in_valid <= 1'b1;
		op <= o;
		force_x <= fx;
		force_y <= fy;
		time_step <= dt;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_word(o, fx, fy, dt);
	endtask

	// bursts of random length, random gaps between them unless gapless
	task automatic pace(bit gapless);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(1, 24);
		gap = gapless ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.load_reg(idx, data);
	endtask

	task automatic fixed_room(logic [31:0] rad, logic [31:0] lw, logic [31:0] rw,
			logic [31:0] gnd, logic [31:0] ceil, logic [31:0] grav,
			logic [31:0] rest, logic [31:0] inv);
		write_reg(REG_RADIUS, rad);
		write_reg(REG_LEFT, lw);
		write_reg(REG_RIGHT, rw);
		write_reg(REG_GROUND, gnd);
		write_reg(REG_CEILING, ceil);
		write_reg(REG_GRAVITY, grav);
		write_reg(REG_RESTITUTION, rest);
		write_reg(REG_INV_MASS, inv);
		cfg_we <= 1'b0;
	endtask

	// plausible room, with some registers thrown to full range when wild
	task automatic random_room(bit wild);
		int lo;
		int gnd;
		logic [31:0] v [8];
		lo = int'($urandom_range(0, 1310720)) - 655360;
		gnd = int'($urandom_range(0, 1310720)) - 655360;
		v[REG_RADIUS] = $urandom_range(0, 131072);
		v[REG_LEFT] = lo;
		v[REG_RIGHT] = lo + int'($urandom_range(131072, 2621440));
		v[REG_GROUND] = gnd;
		v[REG_CEILING] = gnd + int'($urandom_range(131072, 1310720));
		v[REG_GRAVITY] = int'($urandom_range(0, 1310720)) - 1048576;
		v[REG_RESTITUTION] = $urandom_range(0, 72000);
		v[REG_INV_MASS] = $urandom_range(0, 131072);
		for (int i = 0; i < 8; i++) begin
			if (wild && $urandom_range(3) == 0)
				v[i] = $urandom;
			write_reg(3'(i), v[i]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] rand_force();
		int f;
		f = $urandom_range(0, 2621440);
		if ($urandom_range(1))
			f = -f;
		return f;
	endfunction

	// mostly reset-launch-tick sequences, some full-range noise words
	task automatic run_items(int count, bit gapless);
		int sent;
		int len;
		logic [15:0] dt;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(9) == 0) begin
				send_word(2'($urandom_range(3)), $urandom, $urandom, 16'($urandom));
				sent++;
				pace(gapless);
			end else begin
				send_word(OP_RESET, $urandom, $urandom, 16'($urandom));
				sent++;
				pace(gapless);
				len = $urandom_range(5, 40);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(9) < 3)
						send_word(OP_LAUNCH, rand_force(), rand_force(), 16'($urandom));
					else begin
						dt = ($urandom_range(9) == 0) ? 16'($urandom) :
							16'($urandom_range(0, 8000));
						send_word(OP_TICK, $urandom, $urandom, dt);
					end
					sent++;
					pace(gapless);
				end
			end
		end
	endtask

	task automatic directed_words();
		send_word(OP_UNUSED, 32'hffffffff, 32'hffffffff, 16'hffff);
		send_word(OP_TICK, 32'h0, 32'h0, 16'h0000);
		// push left and run into the left wall
		send_word(OP_LAUNCH, -32'sd1310720, 32'h0, 16'h0);
		send_word(OP_TICK, 32'h0, 32'h0, 16'h0000);
		send_word(OP_TICK, 32'h0, 32'h0, 16'hffff);
		// across to the right wall
		send_word(OP_LAUNCH, 32'sd5242880, 32'h0, 16'h0);
		send_word(OP_TICK, 32'h0, 32'h0, 16'hffff);
		// up into the ceiling, then down into the ground
		send_word(OP_LAUNCH, 32'h0, 32'sd5242880, 16'h0);
		send_word(OP_TICK, 32'h0, 32'h0, 16'hffff);
		send_word(OP_LAUNCH, 32'h0, -32'sd10485760, 16'h0);
		send_word(OP_TICK, 32'h0, 32'h0, 16'hffff);
		send_word(OP_TICK, 32'h0, 32'h0, 16'h0000);
		send_word(OP_RESET, 32'h0, 32'h0, 16'h0);
		// speeds and positions pinned at the rails
		send_word(OP_LAUNCH, 32'h7fffffff, 32'h7fffffff, 16'h0);
		send_word(OP_LAUNCH, 32'h7fffffff, 32'h7fffffff, 16'h0);
		send_word(OP_TICK, 32'h0, 32'h0, 16'hffff);
		send_word(OP_LAUNCH, 32'h80000000, 32'h80000000, 16'h0);
		send_word(OP_LAUNCH, 32'h80000000, 32'h80000000, 16'h0);
		send_word(OP_LAUNCH, 32'h80000000, 32'h80000000, 16'h0);
		send_word(OP_TICK, 32'h0, 32'h0, 16'hffff);
		send_word(OP_TICK, 32'h0, 32'h0, 16'h0001);
		send_word(OP_UNUSED, 32'h0, 32'h0, 16'h0);
		send_word(OP_RESET, 32'h0, 32'h0, 16'h0);
	endtask

	initial begin
		int waited;
		sb = new();
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_words();
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph)
				0: ;
				1: random_room(1'b0);
				// radius masked to zero, widest room, strongest pull down
				2: fixed_room(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
					32'h7fffffff, 32'h80000000, 32'd65536, 32'h01ffffff);
				// largest radius in a room of zero size, restitution above one
				3: fixed_room(32'hffffffff, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7fffffff,
					32'hffffffff, 32'h0);
				4: fixed_room(32'd16384, 32'h0, 32'd1310720, 32'h0, 32'd655360, 32'h0,
					32'h0, 32'd16777216);
				default: random_room(1'b1);
			endcase
			if (ph == 1)
				hold_kick = 1'b1;
			run_items(250, ph == 1 || ph == 5);
		end
		in_valid <= 1'b0;
		waited = 0;
		while (sb.outstanding() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (5) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> files.f
rtl/core/bbes_pkg.sv
rtl/core/bbes_prep.sv
rtl/core/bbes_step.sv
rtl/core/bouncing_ball_euler_step_unit.sv
bench/bouncing_ball_euler_step_unit_tb.sv
